// File: design/wnf_pkg.sv
// Shared types, character constants and codes for the wildcard name filter.
package wnf_pkg;

   // Fixed register and field widths.
   localparam int PAT_STORE  = 32;
   localparam int WORD_W     = 64;
   localparam int WORDS      = 4;
   localparam int LEN_W      = 6;
   localparam int FILTER_W   = 2;
   localparam int KIND_W     = 2;
   localparam int CHAR_W     = 8;
   localparam int CSR_IDX_W  = 3;

   // Pattern characters with a special meaning, and the case folding range.
   localparam logic [CHAR_W-1:0] CHAR_QUESTION = 8'h3F;
   localparam logic [CHAR_W-1:0] CHAR_STAR     = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_NUL      = 8'h00;
   localparam logic [CHAR_W-1:0] CASE_BIT      = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z  = 8'h7A;

   // Type filter settings.
   localparam logic [FILTER_W-1:0] FILTER_ALL   = 2'd0;
   localparam logic [FILTER_W-1:0] FILTER_FILES = 2'd1;
   localparam logic [FILTER_W-1:0] FILTER_DIRS  = 2'd2;

   // Entry kinds.
   localparam logic [KIND_W-1:0] KIND_FILE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DIR  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_3  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE_FILTER = 3'd5;

   // Input transaction: one character of an entry name.
   typedef struct packed {
      logic [CHAR_W-1:0] name_char;
      logic              last_char;
      logic [KIND_W-1:0] entry_kind;
   } req_payload_type;

   // Result transaction: one per name.
   typedef struct packed {
      logic name_matched;
      logic accepted;
   } rsp_payload_type;

   // Signals handed from one cell to the next one up the chain.
   typedef struct packed {
      logic in_use;     // this and all lower positions are part of the pattern
      logic adv;        // a literal or '?' match moves onto the next position
      logic prop;       // star closure of the stepped vector reaches the next position
      logic init_prop;  // star closure of the start vector reaches the next position
   } link_type;

   // Per-cycle control shared by all cells.
   typedef struct packed {
      logic fresh;      // the live vector is the start vector of the current pattern
      logic load;       // a non-final character was taken: store the stepped vector
   } cell_ctrl_type;

   // Folds a to z onto A to Z.
   function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         r = c & ~CASE_BIT;
      end
      return r;
   endfunction

endpackage

// File: design/wildcard_name_filter.sv
// Top level of the wildcard name filter: registers, cell chain and result stage.
//
// Names arrive on the req_ channel one character per transaction, with
// last_char set on the final character and entry_kind valid with it. The
// pattern lives in the csr_ registers: four words of pattern bytes, the
// pattern length and the entry type filter. A write to a decoded register
// restarts any name in progress; csr_ready is always high.
// A row of one cell per pattern position holds the live positions and
// steps them on each character, so one character is taken every clock
// while req_stall is low. Each final character yields one rsp_ transaction,
// registered, in the cycle after it is taken; other characters yield none.
// A result that waits under rsp_stall holds the output register, and
// req_stall is raised only while that register is full and stalled.
// Synchronous reset loads the default registers (empty pattern, files only)
// and empties the output register; no clearing pass is needed.
module wildcard_name_filter #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  wnf_pkg::req_payload_type          req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output wnf_pkg::rsp_payload_type          rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wnf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wnf_pkg::WORD_W-1:0]        csr_data
);

   localparam int CELLS = (MAX_PATTERN < wnf_pkg::PAT_STORE) ? MAX_PATTERN
                                                             : wnf_pkg::PAT_STORE;

   logic [wnf_pkg::WORDS-1:0][wnf_pkg::WORD_W-1:0] pattern_ff, pattern_in;
   logic [wnf_pkg::LEN_W-1:0]    length_ff, length_in;
   logic [wnf_pkg::FILTER_W-1:0] filter_ff, filter_in;
   logic                         fresh_ff, fresh_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   wnf_pkg::rsp_payload_type     rsp_payload_ff, rsp_payload_in;

   logic                         req_accept;
   logic                         csr_write;
   logic                         csr_hit;
   logic [wnf_pkg::CHAR_W-1:0]   name_folded;
   wnf_pkg::cell_ctrl_type       ctrl;
   wnf_pkg::link_type            links [CELLS:0];
   logic [CELLS-1:0]             end_hits;
   logic                         matched;
   logic                         type_pass;

   // Handshakes.
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // Configuration registers.
   always_comb begin
      pattern_in = pattern_ff;
      length_in  = length_ff;
      filter_in  = filter_ff;
      csr_hit    = 1'b0;
      if (csr_write) begin
         case (csr_index)
            wnf_pkg::CSR_PATTERN_0: begin
               pattern_in[0] = csr_data;
               csr_hit       = 1'b1;
            end
            wnf_pkg::CSR_PATTERN_1: begin
               pattern_in[1] = csr_data;
               csr_hit       = 1'b1;
            end
            wnf_pkg::CSR_PATTERN_2: begin
               pattern_in[2] = csr_data;
               csr_hit       = 1'b1;
            end
            wnf_pkg::CSR_PATTERN_3: begin
               pattern_in[3] = csr_data;
               csr_hit       = 1'b1;
            end
            wnf_pkg::CSR_PATTERN_LEN: begin
               length_in = csr_data[wnf_pkg::LEN_W-1:0];
               csr_hit   = 1'b1;
            end
            wnf_pkg::CSR_TYPE_FILTER: begin
               filter_in = csr_data[wnf_pkg::FILTER_W-1:0];
               csr_hit   = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   // Cell chain control: a final character or a decoded register write restarts the name.
   assign name_folded = wnf_pkg::fold_case(req_payload.name_char);
   assign fresh_in    = csr_hit || (req_accept && req_payload.last_char) ||
                        (fresh_ff && !req_accept);
   assign ctrl.fresh  = fresh_ff;
   assign ctrl.load   = req_accept && !req_payload.last_char;

   // Seed of the chain: position zero is live at the start.
   always_comb begin
      links[0].in_use    = 1'b1;
      links[0].adv       = 1'b0;
      links[0].prop      = 1'b0;
      links[0].init_prop = 1'b1;
   end

   // One cell per pattern position.
   for (genvar gi = 0; gi < CELLS; gi++) begin : g_cell
      wnf_cell #(
         .INDEX(gi)
      ) u_cell (
         .clock          (clock),
         .pat_char       (pattern_ff[gi / 8][(gi % 8) * 8 +: wnf_pkg::CHAR_W]),
         .pattern_length (length_ff),
         .name_folded    (name_folded),
         .ctrl           (ctrl),
         .link_in        (links[gi]),
         .link_out       (links[gi + 1]),
         .end_hit        (end_hits[gi])
      );
   end

   // The name matched when the position just past the pattern is live.
   assign matched = (|end_hits) ||
                    (links[CELLS].in_use && (links[CELLS].adv || links[CELLS].prop));

   // Entry type filter.
   always_comb begin
      case (filter_ff)
         wnf_pkg::FILTER_ALL:   type_pass = 1'b1;
         wnf_pkg::FILTER_FILES: type_pass = (req_payload.entry_kind == wnf_pkg::KIND_FILE);
         wnf_pkg::FILTER_DIRS:  type_pass = (req_payload.entry_kind == wnf_pkg::KIND_DIR);
         default:               type_pass = 1'b0;
      endcase
   end

   // Result register: loads on a final character, empties when taken.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (req_accept && req_payload.last_char) begin
         rsp_valid_in                = 1'b1;
         rsp_payload_in.name_matched = matched;
         rsp_payload_in.accepted     = matched && type_pass;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= '0;
         length_ff    <= '0;
         filter_ff    <= wnf_pkg::FILTER_FILES;
         fresh_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         pattern_ff   <= pattern_in;
         length_ff    <= length_in;
         filter_ff    <= filter_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A final character always produces a result in the next cycle.
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_payload.last_char |=> rsp_valid)
      else $error("final character produced no result");

   // A non-final character never creates a result on its own.
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_payload.last_char && !rsp_valid |=> !rsp_valid)
      else $error("result appeared without a final character");

   // An accepted entry must have a matching name.
   a_accept_needs_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_payload.accepted || rsp_payload.name_matched))
      else $error("entry accepted without a name match");

   // After a final character the next name starts from the start vector.
   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_payload.last_char |=> fresh_ff)
      else $error("live vector not restarted after a final character");

   // Input is held back only by a full, stalled result register.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with an empty result register");

endmodule

// File: design/wnf_cell.sv
// One pattern position: holds its live bit and steps it on each character.
module wnf_cell #(
   parameter int INDEX = 0
) (
   input  logic                           clock,
   input  logic [wnf_pkg::CHAR_W-1:0]     pat_char,
   input  logic [wnf_pkg::LEN_W-1:0]      pattern_length,
   input  logic [wnf_pkg::CHAR_W-1:0]     name_folded,
   input  wnf_pkg::cell_ctrl_type         ctrl,
   input  wnf_pkg::link_type              link_in,
   output wnf_pkg::link_type              link_out,
   output logic                           end_hit
);

   localparam logic [wnf_pkg::LEN_W:0] INDEX_V = (wnf_pkg::LEN_W + 1)'(INDEX);

   logic active_ff;
   logic active_in;
   logic use_here;
   logic is_star;
   logic is_question;
   logic char_hit;
   logic init_bit;
   logic cur_bit;
   logic next_bit;

   // The position takes part while it lies below the length and before any zero byte.
   assign use_here    = link_in.in_use && ({1'b0, pattern_length} > INDEX_V)
                        && (pat_char != wnf_pkg::CHAR_NUL);
   assign is_star     = (pat_char == wnf_pkg::CHAR_STAR);
   assign is_question = (pat_char == wnf_pkg::CHAR_QUESTION);
   assign char_hit    = is_question || (wnf_pkg::fold_case(pat_char) == name_folded);

   // Start value of this position, and the live value seen by this character.
   assign init_bit = link_in.init_prop;
   assign cur_bit  = ctrl.fresh ? init_bit : active_ff;

   // A star keeps its own position; closure from below is added in.
   assign next_bit = link_in.adv || link_in.prop || (cur_bit && is_star && use_here);

   // Hand the step and both closures on to the next position.
   always_comb begin
      link_out.in_use    = use_here;
      link_out.adv       = cur_bit && use_here && !is_star && char_hit;
      link_out.prop      = next_bit && is_star && use_here;
      link_out.init_prop = init_bit && is_star && use_here;
   end

   // The first unused position is the end of the pattern.
   assign end_hit = link_in.in_use && !use_here && next_bit;

   // Live bit storage.
   assign active_in = ctrl.load ? next_bit : active_ff;

   always_ff @(posedge clock) begin
      active_ff <= active_in;
   end

endmodule

// File: bench/wildcard_name_filter_tb.sv
// Self-checking testbench for the wildcard name filter: stimulus, prediction and checking.
`timescale 1ns / 100ps

module wildcard_name_filter_tb;

   localparam int PAT_LIMIT    = 32;
   localparam int ROUNDS       = 10;
   localparam int ROUND_CHARS  = 123;
   localparam int SETTLE       = 6;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 300000;

   // Register indexes that the block decodes to nothing.
   localparam logic [wnf_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [wnf_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   // Entry kinds and the filter setting that the package leaves unnamed.
   localparam logic [wnf_pkg::KIND_W-1:0]   KIND_OTHER  = 2'd0;
   localparam logic [wnf_pkg::KIND_W-1:0]   KIND_SPARE  = 2'd3;
   localparam logic [wnf_pkg::FILTER_W-1:0] FILTER_NONE = 2'd3;

   // Upper-case letter range and the first digit.
   localparam logic [wnf_pkg::CHAR_W-1:0] UPPER_A    = wnf_pkg::CHAR_LOWER_A - wnf_pkg::CASE_BIT;
   localparam logic [wnf_pkg::CHAR_W-1:0] UPPER_Z    = wnf_pkg::CHAR_LOWER_Z - wnf_pkg::CASE_BIT;
   localparam logic [wnf_pkg::CHAR_W-1:0] DIGIT_ZERO = 8'h30;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   wnf_pkg::req_payload_type          req_payload = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b1;
   wnf_pkg::rsp_payload_type          rsp_payload;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [wnf_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [wnf_pkg::WORD_W-1:0]        csr_data = '0;

   // Predictor copy of the registers and of the live pattern positions.
   logic [wnf_pkg::WORD_W-1:0]        pat_word [wnf_pkg::WORDS];
   logic [wnf_pkg::LEN_W-1:0]         pat_len;
   logic [wnf_pkg::FILTER_W-1:0]      type_sel;
   logic [wnf_pkg::PAT_STORE:0]       live_cells;

   // Characters waiting to be sent, and verdicts waiting to come back.
   wnf_pkg::req_payload_type          char_queue [$];
   wnf_pkg::rsp_payload_type          verdict_queue [$];
   logic [wnf_pkg::CHAR_W-1:0]        name_buf [$];
   logic [wnf_pkg::CHAR_W-1:0]        pattern_draft [wnf_pkg::PAT_STORE];
   wnf_pkg::rsp_payload_type          oldest_verdict;

   int                     send_idle_pct = 0;
   int                     recv_idle_pct = 0;
   logic                   hold_go = 1'b0;
   int                     hold_left = 0;
   int unsigned            cycle_count = 0;
   int                     mismatch_count = 0;
   int                     queued_chars = 0;

   wildcard_name_filter #(
      .MAX_PATTERN(PAT_LIMIT)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string what);
      $display("cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------- predictor

   function automatic logic [wnf_pkg::CHAR_W-1:0] to_upper(
         input logic [wnf_pkg::CHAR_W-1:0] c);
      logic [wnf_pkg::CHAR_W-1:0] r;
      r = c;
      if (c >= wnf_pkg::CHAR_LOWER_A && c <= wnf_pkg::CHAR_LOWER_Z) begin
         r = c - wnf_pkg::CASE_BIT;
      end
      return r;
   endfunction

   function automatic logic [wnf_pkg::CHAR_W-1:0] pattern_char(input int i);
      return pat_word[i / 8][(i % 8) * 8 +: 8];
   endfunction

   // Pattern length in effect: clipped to the store and cut at the first zero byte.
   function automatic int usable_length();
      int n;
      int i;
      n = pat_len;
      if (n > PAT_LIMIT) n = PAT_LIMIT;
      if (n > wnf_pkg::PAT_STORE) n = wnf_pkg::PAT_STORE;
      for (i = 0; i < n; i++) begin
         if (pattern_char(i) == wnf_pkg::CHAR_NUL) return i;
      end
      return n;
   endfunction

   // A live star also makes the position after it live, in a chain upward.
   function automatic logic [wnf_pkg::PAT_STORE:0] star_closure(
         input logic [wnf_pkg::PAT_STORE:0] v, input int len);
      int i;
      for (i = 0; i < len; i++) begin
         if (v[i] && pattern_char(i) == wnf_pkg::CHAR_STAR) v[i + 1] = 1'b1;
      end
      return v;
   endfunction

   function automatic void restart_name();
      live_cells = star_closure({{wnf_pkg::PAT_STORE{1'b0}}, 1'b1}, usable_length());
   endfunction

   function automatic void clear_settings();
      int w;
      for (w = 0; w < wnf_pkg::WORDS; w++) pat_word[w] = '0;
      pat_len = '0;
      type_sel = wnf_pkg::FILTER_FILES;
      restart_name();
   endfunction

   function automatic void apply_csr(input logic [wnf_pkg::CSR_IDX_W-1:0] idx,
                                     input logic [wnf_pkg::WORD_W-1:0] data);
      logic known;
      known = 1'b1;
      case (idx)
         wnf_pkg::CSR_PATTERN_0, wnf_pkg::CSR_PATTERN_1,
         wnf_pkg::CSR_PATTERN_2, wnf_pkg::CSR_PATTERN_3: begin
            pat_word[idx[1:0]] = data;
         end
         wnf_pkg::CSR_PATTERN_LEN: begin
            pat_len = data[wnf_pkg::LEN_W-1:0];
         end
         wnf_pkg::CSR_TYPE_FILTER: begin
            type_sel = data[wnf_pkg::FILTER_W-1:0];
         end
         default: begin
            known = 1'b0;
         end
      endcase
      if (known) restart_name();
   endfunction

   // Steps the live positions by one name character; a final character yields a verdict.
   function automatic void advance_name(input wnf_pkg::req_payload_type item);
      logic [wnf_pkg::CHAR_W-1:0]  c;
      logic [wnf_pkg::CHAR_W-1:0]  p;
      logic [wnf_pkg::PAT_STORE:0] nxt;
      logic                        kind_ok;
      wnf_pkg::rsp_payload_type    verdict;
      int                          len;
      int                          i;
      c = to_upper(item.name_char);
      len = usable_length();
      nxt = '0;
      for (i = 0; i < len; i++) begin
         if (live_cells[i]) begin
            p = pattern_char(i);
            if (p == wnf_pkg::CHAR_STAR) begin
               nxt[i] = 1'b1;
            end else if (p == wnf_pkg::CHAR_QUESTION || to_upper(p) == c) begin
               nxt[i + 1] = 1'b1;
            end
         end
      end
      nxt = star_closure(nxt, len);
      if (!item.last_char) begin
         live_cells = nxt;
      end else begin
         case (type_sel)
            wnf_pkg::FILTER_ALL:   kind_ok = 1'b1;
            wnf_pkg::FILTER_FILES: kind_ok = (item.entry_kind == wnf_pkg::KIND_FILE);
            wnf_pkg::FILTER_DIRS:  kind_ok = (item.entry_kind == wnf_pkg::KIND_DIR);
            default:               kind_ok = 1'b0;
         endcase
         verdict.name_matched = nxt[len];
         verdict.accepted = nxt[len] && kind_ok;
         verdict_queue.push_back(verdict);
         restart_name();
      end
   endfunction

   // ---------------------------------------------------------------- driver and monitor

   // Sender: presents the next queued character once the previous one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) advance_name(req_payload);
         if (!req_valid || !req_stall) begin
            if (char_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_payload <= char_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, or a long hold-off counted down here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_go) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Compares each result transaction with the oldest predicted verdict.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected result: matched %0b accepted %0b",
                                      rsp_payload.name_matched, rsp_payload.accepted));
         end else begin
            oldest_verdict = verdict_queue.pop_front();
            if (rsp_payload.name_matched !== oldest_verdict.name_matched) begin
               report_mismatch($sformatf("name_matched %0b, expected %0b",
                                         rsp_payload.name_matched,
                                         oldest_verdict.name_matched));
            end
            if (rsp_payload.accepted !== oldest_verdict.accepted) begin
               report_mismatch($sformatf("accepted %0b, expected %0b",
                                         rsp_payload.accepted, oldest_verdict.accepted));
            end
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("wildcard_name_filter_tb: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic write_csr(input logic [wnf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [wnf_pkg::WORD_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, data);
      csr_valid <= 1'b0;
   endtask

   // Waits until every character is taken and every verdict has come back.
   task automatic wait_idle();
      while (char_queue.size() != 0 || req_valid || verdict_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   // Moves the name buffer into the send queue; the kind counts on the final character.
   task automatic queue_name(input logic [wnf_pkg::KIND_W-1:0] kind, input bit finished);
      wnf_pkg::req_payload_type x;
      int i;
      for (i = 0; i < name_buf.size(); i++) begin
         x.name_char = name_buf[i];
         x.last_char = finished && (i == name_buf.size() - 1);
         x.entry_kind = x.last_char ? kind : wnf_pkg::KIND_W'($urandom_range(0, 3));
         char_queue.push_back(x);
      end
      queued_chars += name_buf.size();
      name_buf.delete();
   endtask

   function automatic bit is_letter(input logic [wnf_pkg::CHAR_W-1:0] c);
      return to_upper(c) >= UPPER_A && to_upper(c) <= UPPER_Z;
   endfunction

   function automatic logic [wnf_pkg::CHAR_W-1:0] flip_case(
         input logic [wnf_pkg::CHAR_W-1:0] c);
      if (is_letter(c) && $urandom_range(0, 1) == 1) return c ^ wnf_pkg::CASE_BIT;
      return c;
   endfunction

   function automatic logic [wnf_pkg::CHAR_W-1:0] random_char();
      if ($urandom_range(0, 1) == 0) return wnf_pkg::CHAR_W'($urandom_range(0, 255));
      return flip_case(UPPER_A + wnf_pkg::CHAR_W'($urandom_range(0, 25)));
   endfunction

   function automatic logic [wnf_pkg::CHAR_W-1:0] pattern_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return flip_case(UPPER_A + wnf_pkg::CHAR_W'($urandom_range(0, 25)));
      if (r == 4) return DIGIT_ZERO + wnf_pkg::CHAR_W'($urandom_range(0, 9));
      if (r < 7) return wnf_pkg::CHAR_QUESTION;
      if (r < 9) return wnf_pkg::CHAR_STAR;
      return wnf_pkg::CHAR_W'($urandom_range(1, 255));
   endfunction

   function automatic logic [wnf_pkg::WORD_W-1:0] draft_word(input int w);
      logic [wnf_pkg::WORD_W-1:0] v;
      int b;
      for (b = 0; b < 8; b++) v[b * 8 +: 8] = pattern_draft[w * 8 + b];
      return v;
   endfunction

   // Builds a name that follows the pattern in effect, with random content.
   task automatic build_fitting_name();
      logic [wnf_pkg::CHAR_W-1:0] p;
      int len;
      int i;
      int k;
      int run;
      len = usable_length();
      for (i = 0; i < len; i++) begin
         p = pattern_char(i);
         if (p == wnf_pkg::CHAR_STAR) begin
            run = $urandom_range(0, 3);
            for (k = 0; k < run; k++) name_buf.push_back(random_char());
         end else if (p == wnf_pkg::CHAR_QUESTION) begin
            name_buf.push_back(random_char());
         end else begin
            name_buf.push_back(flip_case(p));
         end
      end
   endtask

   // One random name: mostly fitting, some with one flaw, some pure noise.
   task automatic build_random_name();
      int r;
      int k;
      int run;
      r = $urandom_range(0, 99);
      if (r < 85) begin
         build_fitting_name();
         if (r >= 70) begin
            case ($urandom_range(0, 2))
               0: if (name_buf.size() != 0) begin
                     name_buf[$urandom_range(0, name_buf.size() - 1)] = random_char();
                  end
               1: if (name_buf.size() != 0) void'(name_buf.pop_back());
               default: name_buf.push_back(random_char());
            endcase
         end
      end else begin
         run = $urandom_range(1, 6);
         for (k = 0; k < run; k++) begin
            name_buf.push_back(wnf_pkg::CHAR_W'($urandom_range(0, 255)));
         end
      end
      if (name_buf.size() == 0) name_buf.push_back(random_char());
   endtask

   // New pattern, length and filter for one round of random names.
   task automatic pick_settings(input int round);
      logic [wnf_pkg::WORD_W-1:0] data;
      int plen;
      int len_field;
      int i;
      bit tail_junk;
      plen = ($urandom_range(0, 4) == 0) ? $urandom_range(9, wnf_pkg::PAT_STORE)
                                         : $urandom_range(1, 8);
      if (round == 5) plen = wnf_pkg::PAT_STORE;
      tail_junk = $urandom_range(0, 1);
      for (i = 0; i < wnf_pkg::PAT_STORE; i++) begin
         if (i < plen) pattern_draft[i] = pattern_byte();
         else pattern_draft[i] = tail_junk ? wnf_pkg::CHAR_W'($urandom_range(0, 255))
                                           : wnf_pkg::CHAR_NUL;
      end
      case (round)
         0: len_field = 0;
         1: len_field = 63;
         default: begin
            case ($urandom_range(0, 9))
               6: len_field = $urandom_range(0, plen);
               7: len_field = $urandom_range(33, 63);
               8: len_field = $urandom_range(0, 63);
               9: len_field = (plen + 4 > 63) ? 63 : plen + $urandom_range(1, 4);
               default: len_field = plen;
            endcase
         end
      endcase
      if ($urandom_range(0, 2) == 0) begin
         write_csr(wnf_pkg::CSR_IDX_W'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)),
                   {$urandom, $urandom});
      end
      write_csr(wnf_pkg::CSR_PATTERN_0, draft_word(0));
      write_csr(wnf_pkg::CSR_PATTERN_1, draft_word(1));
      write_csr(wnf_pkg::CSR_PATTERN_2, draft_word(2));
      write_csr(wnf_pkg::CSR_PATTERN_3, draft_word(3));
      data = {$urandom, $urandom};
      data[wnf_pkg::LEN_W-1:0] = wnf_pkg::LEN_W'(len_field);
      write_csr(wnf_pkg::CSR_PATTERN_LEN, data);
      data = {$urandom, $urandom};
      data[wnf_pkg::FILTER_W-1:0] = wnf_pkg::FILTER_W'(round % 4);
      write_csr(wnf_pkg::CSR_TYPE_FILTER, data);
   endtask

   // Main sequence: reset, directed names, then rounds of random names.
   initial begin
      int round;
      int target;
      clear_settings();
      send_idle_pct = 25;
      recv_idle_pct = 65;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Empty pattern after reset: nothing matches.
      name_buf = '{8'h41};
      queue_name(wnf_pkg::KIND_FILE, 1'b1);
      wait_idle();

      // Pattern "A?*Z", all entry types.
      write_csr(wnf_pkg::CSR_PATTERN_0, 64'h0000_0000_5A2A_3F41);
      write_csr(wnf_pkg::CSR_PATTERN_LEN, 64'd4);
      write_csr(wnf_pkg::CSR_TYPE_FILTER, {62'd0, wnf_pkg::FILTER_ALL});
      // Lower-case letters fold, and a zero byte is taken by '?'.
      name_buf = '{8'h61, 8'h00, 8'h7A};
      queue_name(KIND_OTHER, 1'b1);
      // The star takes a run of bytes; kind 3 passes only with all types.
      name_buf = '{8'h41, 8'hFF, 8'h62, 8'h63, 8'h5A};
      queue_name(KIND_SPARE, 1'b1);
      // The '?' needs a byte of its own.
      name_buf = '{8'h41, 8'h5A};
      queue_name(wnf_pkg::KIND_DIR, 1'b1);
      // A name cut short by a register write starts over.
      name_buf = '{8'h41, 8'h42};
      queue_name(wnf_pkg::KIND_FILE, 1'b0);
      wait_idle();
      write_csr(wnf_pkg::CSR_TYPE_FILTER, {62'd0, FILTER_NONE});
      // A filter of 3 rejects every matching name.
      name_buf = '{8'h41, 8'h42, 8'h5A};
      queue_name(wnf_pkg::KIND_FILE, 1'b1);
      wait_idle();

      // A zero byte ends the pattern early: "A*Z", directories only.
      write_csr(wnf_pkg::CSR_PATTERN_0, 64'h0000_0000_005A_2A41);
      write_csr(wnf_pkg::CSR_PATTERN_LEN, 64'd6);
      write_csr(wnf_pkg::CSR_TYPE_FILTER, {62'd0, wnf_pkg::FILTER_DIRS});
      name_buf = '{8'h41, 8'h7A};
      queue_name(wnf_pkg::KIND_DIR, 1'b1);
      wait_idle();

      // Full store of stars ending in 'Q', length beyond the store.
      write_csr(wnf_pkg::CSR_PATTERN_0, {8{wnf_pkg::CHAR_STAR}});
      write_csr(wnf_pkg::CSR_PATTERN_1, {8{wnf_pkg::CHAR_STAR}});
      write_csr(wnf_pkg::CSR_PATTERN_2, {8{wnf_pkg::CHAR_STAR}});
      write_csr(wnf_pkg::CSR_PATTERN_3, 64'h512A_2A2A_2A2A_2A2A);
      write_csr(wnf_pkg::CSR_PATTERN_LEN, 64'd63);
      write_csr(wnf_pkg::CSR_TYPE_FILTER, {62'd0, wnf_pkg::FILTER_ALL});
      name_buf = '{8'h71};
      queue_name(KIND_OTHER, 1'b1);
      name_buf = '{8'h71, 8'h61};
      queue_name(wnf_pkg::KIND_FILE, 1'b1);
      wait_idle();

      // Random rounds; the sender pauses at each round boundary until all verdicts are in.
      for (round = 0; round < ROUNDS; round++) begin
         if (round == 4) begin
            send_idle_pct = 65;
            recv_idle_pct = 25;
         end else if (round == 7) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         pick_settings(round);
         target = queued_chars + ROUND_CHARS;
         while (queued_chars < target) begin
            build_random_name();
            queue_name(wnf_pkg::KIND_W'($urandom_range(0, 3)), 1'b1);
         end
         // Sometimes leave a name unfinished so the next write to a decoded register restarts it.
         if ($urandom_range(0, 2) == 0) begin
            build_fitting_name();
            if (name_buf.size() == 0) name_buf.push_back(random_char());
            queue_name(KIND_OTHER, 1'b0);
         end
         // Long receiver hold-off while the sender keeps offering characters.
         if (round == 2 || round == 8) begin
            @(posedge clock);
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
         end
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("wildcard_name_filter_tb: clean");
      end else begin
         $display("wildcard_name_filter_tb: errors");
      end
      $finish;
   end

endmodule
